>>> design/gcode_line_filter_classifier_defines.svh
// ---------------------------------------------------------------------------
// gcode line filter classifier assertion macros
// shared assertion shorthands for the classifier rtl
// ---------------------------------------------------------------------------
`ifndef GCODE_LINE_FILTER_CLASSIFIER_DEFINES_SVH
`define GCODE_LINE_FILTER_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GCLF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GCLF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gclf_pkg.sv
// ---------------------------------------------------------------------------
// gclf_pkg
// character codes, byte class word and classify function for the classifier
// ---------------------------------------------------------------------------
package gclf_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_G    = 8'h47;
    localparam logic [7:0] CHAR_UPPER_M    = 8'h4D;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    localparam logic [9:0] CODE_MAX       = 10'd1023;
    localparam logic [9:0] FREE_TEXT_CODE = 10'd117;

    // everything the back end needs to know about one text byte
    typedef struct packed {
        logic       last;
        logic       newline;
        logic       blank;
        logic       space_class;
        logic       upper;
        logic       underscore;
        logic       cr;
        logic       equals;
        logic       comment;
        logic       digit;
        logic [3:0] digit_val;
        logic       value_start;
        logic       word_letter;
        logic       letter_m;
        logic       letter_g;
    } byte_class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic is_word_letter(logic [7:0] b);
        logic hit;
        case (b)
            8'h58, 8'h59, 8'h5A, 8'h41, 8'h42, 8'h43,
            8'h55, 8'h56, 8'h57, 8'h45, 8'h46, 8'h53,
            8'h50, 8'h52, 8'h54, 8'h49, 8'h4A, 8'h4B,
            8'h44, 8'h48, 8'h4C, 8'h4F, 8'h4E, 8'h51: hit = 1'b1;
            default:                                 hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic byte_class_t classify(logic [7:0] b, logic last);
        byte_class_t c;
        c             = '0;
        c.last        = last;
        c.newline     = (b == CHAR_LF);
        c.blank       = (b == CHAR_SPACE) || (b == CHAR_TAB);
        c.space_class = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
        c.upper       = (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z);
        c.underscore  = (b == CHAR_UNDERSCORE);
        c.cr          = (b == CHAR_CR);
        c.equals      = (b == CHAR_EQUALS);
        c.comment     = (b == CHAR_SEMICOLON) || (b == CHAR_LPAREN);
        c.digit       = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        c.digit_val   = b[3:0];
        c.value_start = c.digit || (b == CHAR_DOT) || (b == CHAR_MINUS)
                        || (b == CHAR_PLUS);
        c.word_letter = is_word_letter(b);
        c.letter_m    = (b == CHAR_UPPER_M);
        c.letter_g    = (b == CHAR_UPPER_G);
        return c;
    endfunction

endpackage

>>> design/gclf_front.sv
// ---------------------------------------------------------------------------
// gclf_front
// text input handshake and per-byte character classification
// ---------------------------------------------------------------------------
module gclf_front (
    input  logic                   text_valid,
    output logic                   text_stall,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    input  gclf_pkg::fifo_status_t fifo_status,
    output logic                   push,
    output gclf_pkg::byte_class_t  push_class
);

    // stall only on a full queue, never on valid
    assign text_stall = fifo_status.full;
    assign push       = text_valid && !fifo_status.full;
    assign push_class = gclf_pkg::classify(text_byte, end_of_text);

endmodule

>>> design/gclf_fifo.sv
// ---------------------------------------------------------------------------
// gclf_fifo
// short register queue between the classifier front and the line back end
// ---------------------------------------------------------------------------
`include "gcode_line_filter_classifier_defines.svh"

module gclf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output gclf_pkg::fifo_status_t status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0]  entries_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_data     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `GCLF_ASSERT_IMP(a_fifo_no_overflow, status.full, !push, "push into a full queue")
    `GCLF_ASSERT_IMP(a_fifo_no_underflow, status.empty, !pop, "pop from an empty queue")

endmodule

>>> design/gclf_back.sv
// ---------------------------------------------------------------------------
// gclf_back
// per-line command and word scanners with registered verdict output
// ---------------------------------------------------------------------------
`include "gcode_line_filter_classifier_defines.svh"

module gclf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  gclf_pkg::byte_class_t item,
    output logic                  pop,
    output logic                  verdict_valid,
    input  logic                  verdict_stall,
    output logic                  filter_line,
    output logic                  extended_command,
    output logic                  word_without_value
);

    typedef enum logic [2:0] {
        CMD_LEAD,
        CMD_FIRST,
        CMD_RUN,
        CMD_MATCH,
        CMD_REJECT
    } cmd_phase_t;

    typedef enum logic [2:0] {
        WORD_LEAD,
        WORD_CODE,
        WORD_GAP,
        WORD_WAIT,
        WORD_VALUE,
        WORD_M117,
        WORD_SKIP
    } word_phase_t;

    cmd_phase_t  cmd_reg, cmd_next;
    word_phase_t word_reg, word_next;
    logic [9:0]  code_reg, code_next;
    logic        code_is_m_reg, code_is_m_next;
    logic        missing_reg, missing_next;
    logic        comment_reg, comment_next;
    logic        verdict_valid_reg, verdict_valid_next;
    logic        filter_reg, filter_next;
    logic        ext_reg, ext_next;
    logic        wwv_reg, wwv_next;

    logic        take;
    logic        line_end;
    logic        ext;
    logic [13:0] code_sum;

    // an item moves unless the verdict register is full and held
    assign take     = item_valid && !(verdict_valid_reg && verdict_stall);
    assign pop      = take;
    assign line_end = item.newline || item.last;
    assign code_sum = ({4'b0, code_reg} << 3) + ({4'b0, code_reg} << 1)
                      + {10'b0, item.digit_val};

    always_comb
    begin
        cmd_next           = cmd_reg;
        word_next          = word_reg;
        code_next          = code_reg;
        code_is_m_next     = code_is_m_reg;
        missing_next       = missing_reg;
        comment_next       = comment_reg;
        filter_next        = filter_reg;
        ext_next           = ext_reg;
        wwv_next           = wwv_reg;
        verdict_valid_next = verdict_valid_reg && verdict_stall;
        ext                = 1'b0;

        if (take)
        begin
            if (!item.newline)
            begin
                // extended command pattern
                case (cmd_reg)
                    CMD_LEAD:
                    begin
                        if (!item.blank)
                        begin
                            cmd_next = item.upper ? CMD_FIRST : CMD_REJECT;
                        end
                    end
                    CMD_FIRST:
                    begin
                        cmd_next = (item.upper || item.underscore) ? CMD_RUN : CMD_REJECT;
                    end
                    CMD_RUN:
                    begin
                        if (!(item.upper || item.underscore))
                        begin
                            cmd_next = (item.blank || item.cr || item.equals)
                                       ? CMD_MATCH : CMD_REJECT;
                        end
                    end
                    default:
                    begin
                        cmd_next = cmd_reg;
                    end
                endcase

                // g/m word scan up to the first comment
                if (!comment_reg)
                begin
                    if (item.comment)
                    begin
                        comment_next = 1'b1;
                        if (word_reg == WORD_WAIT)
                        begin
                            missing_next = 1'b1;
                        end
                        word_next = WORD_SKIP;
                    end
                    else
                    begin
                        case (word_reg)
                            WORD_LEAD:
                            begin
                                if (!item.blank)
                                begin
                                    if (item.letter_m || item.letter_g)
                                    begin
                                        word_next      = WORD_CODE;
                                        code_is_m_next = item.letter_m;
                                        code_next      = '0;
                                    end
                                    else
                                    begin
                                        word_next = WORD_SKIP;
                                    end
                                end
                            end
                            WORD_CODE:
                            begin
                                if (item.digit)
                                begin
                                    code_next = (code_sum > {4'b0, gclf_pkg::CODE_MAX})
                                                ? gclf_pkg::CODE_MAX : code_sum[9:0];
                                end
                                else if (code_is_m_reg
                                         && (code_reg == gclf_pkg::FREE_TEXT_CODE))
                                begin
                                    word_next = WORD_M117;
                                    if (!item.blank)
                                    begin
                                        missing_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    word_next = item.word_letter ? WORD_WAIT : WORD_GAP;
                                end
                            end
                            WORD_GAP:
                            begin
                                word_next = item.word_letter ? WORD_WAIT : WORD_GAP;
                            end
                            WORD_WAIT:
                            begin
                                if (item.value_start)
                                begin
                                    word_next = WORD_VALUE;
                                end
                                else
                                begin
                                    missing_next = 1'b1;
                                    word_next    = item.word_letter ? WORD_WAIT : WORD_GAP;
                                end
                            end
                            WORD_VALUE:
                            begin
                                if (item.space_class || item.word_letter)
                                begin
                                    word_next = item.word_letter ? WORD_WAIT : WORD_GAP;
                                end
                            end
                            WORD_M117:
                            begin
                                if (!item.blank)
                                begin
                                    missing_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                word_next = word_reg;
                            end
                        endcase
                    end
                end
            end

            if (line_end)
            begin
                // letter still waiting for its value at line end
                if (word_next == WORD_WAIT)
                begin
                    missing_next = 1'b1;
                end
                ext                = (cmd_next == CMD_RUN) || (cmd_next == CMD_MATCH);
                filter_next        = ext || missing_next;
                ext_next           = ext;
                wwv_next           = missing_next;
                verdict_valid_next = 1'b1;

                cmd_next       = CMD_LEAD;
                word_next      = WORD_LEAD;
                code_next      = '0;
                code_is_m_next = 1'b0;
                missing_next   = 1'b0;
                comment_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg           <= CMD_LEAD;
            word_reg          <= WORD_LEAD;
            code_reg          <= '0;
            code_is_m_reg     <= 1'b0;
            missing_reg       <= 1'b0;
            comment_reg       <= 1'b0;
            verdict_valid_reg <= 1'b0;
            filter_reg        <= 1'b0;
            ext_reg           <= 1'b0;
            wwv_reg           <= 1'b0;
        end
        else
        begin
            cmd_reg           <= cmd_next;
            word_reg          <= word_next;
            code_reg          <= code_next;
            code_is_m_reg     <= code_is_m_next;
            missing_reg       <= missing_next;
            comment_reg       <= comment_next;
            verdict_valid_reg <= verdict_valid_next;
            filter_reg        <= filter_next;
            ext_reg           <= ext_next;
            wwv_reg           <= wwv_next;
        end
    end

    assign verdict_valid      = verdict_valid_reg;
    assign filter_line        = filter_reg;
    assign extended_command   = ext_reg;
    assign word_without_value = wwv_reg;

    `GCLF_ASSERT_NXT(a_back_line_clears, take && line_end, (cmd_reg == CMD_LEAD) && (word_reg == WORD_LEAD) && !missing_reg && !comment_reg, "line state not cleared after line end")
    `GCLF_ASSERT_NXT(a_back_verdict_loaded, take && line_end, verdict_valid_reg, "line end without verdict")

endmodule

>>> design/gcode_line_filter_classifier.sv
// ---------------------------------------------------------------------------
// gcode_line_filter_classifier
// flags g-code lines that are extended commands or carry valueless words
// ---------------------------------------------------------------------------
// text channel: text_valid / text_stall carry one word per cycle unless stalled,
//   a text byte plus end_of_text, which marks the last byte of the text
// verdict channel: verdict_valid / verdict_stall carry one word per line,
//   given at each newline and at an unterminated last line
// the front classifies each byte and pushes it into a short queue; the back
//   pops one byte per cycle unless a held verdict stalls it, runs the command
//   and word scanners and loads the verdict register
// throughput: one text byte per cycle, sustained, while the verdict
//   side keeps up
// a line-ending byte reaches the verdict outputs through the queue, then
//   the verdict register
// a stalled verdict holds in its register and the back end waits with it;
//   the queue keeps taking text until it holds FIFO_DEPTH words, then
//   text_stall rises until the verdict is taken
// reset: queue empties, scanners return to start of line, no verdict valid
// ---------------------------------------------------------------------------
module gcode_line_filter_classifier #(
    parameter int FIFO_DEPTH = gclf_pkg::FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       filter_line,
    output logic       extended_command,
    output logic       word_without_value
);

    localparam int CLASS_W = $bits(gclf_pkg::byte_class_t);

    // front to queue
    gclf_pkg::fifo_status_t fifo_status;
    logic                   push;
    gclf_pkg::byte_class_t  push_class;

    // queue to back
    logic                   pop;
    gclf_pkg::byte_class_t  head_class;

    gclf_front u_front (
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .fifo_status (fifo_status),
        .push        (push),
        .push_class  (push_class)
    );

    gclf_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_class),
        .pop       (pop),
        .pop_data  (head_class),
        .status    (fifo_status)
    );

    // the back end sees a byte whenever the queue holds one
    gclf_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (!fifo_status.empty),
        .item               (head_class),
        .pop                (pop),
        .verdict_valid      (verdict_valid),
        .verdict_stall      (verdict_stall),
        .filter_line        (filter_line),
        .extended_command   (extended_command),
        .word_without_value (word_without_value)
    );

endmodule
